// ===== src/fmti_pkg.sv =====
// ----------------------------------------------------------------------------
// fmti_pkg
// Shared types, sizes, codes and helpers for the trilinear field-map block.
// ----------------------------------------------------------------------------
package fmti_pkg;

    localparam int unsigned GRID_X = 32;
    localparam int unsigned GRID_Y = 32;
    localparam int unsigned GRID_Z = 32;
    localparam int unsigned CELLS  = GRID_X * GRID_Y * GRID_Z;
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned GRID_MAX = (GRID_X > GRID_Y) ?
        ((GRID_X > GRID_Z) ? GRID_X : GRID_Z) : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
    localparam int unsigned IDX_W  = $clog2(GRID_MAX);
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned VEC_W  = 96;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_INV_X    = 3'd3;
    localparam logic [2:0] CFG_INV_Y    = 3'd4;
    localparam logic [2:0] CFG_INV_Z    = 3'd5;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [4:0]  cell_i;
        logic        [4:0]  cell_j;
        logic        [4:0]  cell_k;
        logic signed [31:0] load_bx;
        logic signed [31:0] load_by;
        logic signed [31:0] load_bz;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               outside;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec3;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic                       op;
        logic                       ldok;
        logic [ADDR_W-1:0]          addr;
        t_vec3                      data;
        logic                       outside;
        logic [2:0][IDX_W-1:0]      lo;
        logic [2:0][IDX_W-1:0]      hi;
        logic [2:0][15:0]           d;
    } t_qent;

    function automatic logic [31:0] grid_n(input logic [1:0] ax);
        logic [31:0] n;
        case (ax)
            2'd0:    n = GRID_X;
            2'd1:    n = GRID_Y;
            default: n = GRID_Z;
        endcase
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] i,
                                                    input logic [31:0] j,
                                                    input logic [31:0] k);
        logic [31:0] t;
        t = (i * GRID_Y + j) * GRID_Z + k;
        return t[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/fmti_ram.sv =====
// ----------------------------------------------------------------------------
// fmti_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fmti_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fmti_queue.sv =====
// ----------------------------------------------------------------------------
// fmti_queue
// Short register queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module fmti_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fmti_pkg::t_qent i_ent,
    output logic           o_full,
    output logic           o_valid,
    output fmti_pkg::t_qent o_ent,
    input  logic           i_pop
);

    localparam int unsigned PW = (fmti_pkg::QDEPTH > 1) ? $clog2(fmti_pkg::QDEPTH) : 1;

    fmti_pkg::t_qent r_buf [fmti_pkg::QDEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(fmti_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (PW+1)'(fmti_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_buf[r_wr] <= i_ent;
                r_wr        <= ptr_inc(r_wr);
            end
            if (i_pop && o_valid) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(i_pop && o_valid);
        end
    end

endmodule

// ===== src/fmti_front.sv =====
// ----------------------------------------------------------------------------
// fmti_front
// Holds the configuration, accepts words and locates query positions.
// ----------------------------------------------------------------------------
module fmti_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fmti_pkg::t_in_word  i_in_word,
    input  logic                i_clearing,
    output logic                o_push,
    output fmti_pkg::t_qent     o_ent,
    input  logic                i_full
);

    typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL, F_LOC, F_PUSH} t_fstate;

    t_fstate                    r_state;
    fmti_pkg::t_in_word         r_item;
    fmti_pkg::t_qent            r_ent;
    logic signed [31:0]         r_origin [3];
    logic        [31:0]         r_inv [3];
    logic signed [32:0]         r_diff [3];
    logic        [63:0]         r_p;
    logic                       r_neg;
    logic        [1:0]          r_ax;

    logic        [31:0]             bin;
    logic        [31:0]             n;
    logic                           off;
    logic                           f15;
    logic [fmti_pkg::IDX_W-1:0]     lo;
    logic [fmti_pkg::IDX_W-1:0]     hi;
    logic [15:0]                    d;
    logic                           ldok;

    assign o_in_ready = (r_state == F_IDLE) && !i_clearing;
    assign o_push     = (r_state == F_PUSH);
    assign o_ent      = r_ent;

    assign ldok = ({27'b0, i_in_word.cell_i} < fmti_pkg::GRID_X)
               && ({27'b0, i_in_word.cell_j} < fmti_pkg::GRID_Y)
               && ({27'b0, i_in_word.cell_k} < fmti_pkg::GRID_Z);

    // Bin and half-bin selection from the Q32 coordinate.
    always_comb begin
        bin = r_p[63:32];
        n   = fmti_pkg::grid_n(r_ax);
        off = r_neg || (bin >= n);
        f15 = r_p[31];
        if (!f15 && (bin == '0)) begin
            lo = '0;
            hi = '0;
            d  = '0;
        end else if (f15 && (bin == n - 1)) begin
            lo = fmti_pkg::IDX_W'(n - 1);
            hi = fmti_pkg::IDX_W'(n - 1);
            d  = '0;
        end else begin
            lo = f15 ? bin[fmti_pkg::IDX_W-1:0] : bin[fmti_pkg::IDX_W-1:0] - 1'b1;
            hi = lo + 1'b1;
            d  = {~f15, r_p[30:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ax    <= '0;
            for (int a = 0; a < 3; a++) begin
                r_origin[a] <= '0;
                r_inv[a]    <= 32'd65536;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fmti_pkg::CFG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                    fmti_pkg::CFG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                    fmti_pkg::CFG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                    fmti_pkg::CFG_INV_X:    r_inv[0]    <= i_cfg_data;
                    fmti_pkg::CFG_INV_Y:    r_inv[1]    <= i_cfg_data;
                    fmti_pkg::CFG_INV_Z:    r_inv[2]    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item        <= i_in_word;
                        r_ent.op      <= i_in_word.opcode;
                        r_ent.ldok    <= ldok;
                        r_ent.addr    <= fmti_pkg::cell_addr({27'b0, i_in_word.cell_i},
                                                             {27'b0, i_in_word.cell_j},
                                                             {27'b0, i_in_word.cell_k});
                        r_ent.data    <= {i_in_word.load_bx, i_in_word.load_by,
                                          i_in_word.load_bz};
                        r_ent.outside <= 1'b0;
                        r_state <= (i_in_word.opcode == fmti_pkg::OP_LOAD) ? F_PUSH : F_DIFF;
                    end
                end
                F_DIFF: begin
                    r_diff[0] <= {r_item.pos_x[31], r_item.pos_x}
                               - {r_origin[0][31], r_origin[0]};
                    r_diff[1] <= {r_item.pos_y[31], r_item.pos_y}
                               - {r_origin[1][31], r_origin[1]};
                    r_diff[2] <= {r_item.pos_z[31], r_item.pos_z}
                               - {r_origin[2][31], r_origin[2]};
                    r_ax    <= '0;
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    // A zero inverse width makes the product zero, which is cell 0.
                    r_p     <= r_diff[r_ax][31:0] * r_inv[r_ax];
                    r_neg   <= r_diff[r_ax][32] && (r_inv[r_ax] != '0);
                    r_state <= F_LOC;
                end
                F_LOC: begin
                    if (off) begin
                        r_ent.outside <= 1'b1;
                        r_state       <= F_PUSH;
                    end else begin
                        r_ent.lo[r_ax] <= lo;
                        r_ent.hi[r_ax] <= hi;
                        r_ent.d[r_ax]  <= d;
                        if (r_ax == 2'd2) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= F_MUL;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/fmti_back.sv =====
// ----------------------------------------------------------------------------
// fmti_back
// Owns the grid memory: clears it, applies loads, reads corners and blends.
// ----------------------------------------------------------------------------
module fmti_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  fmti_pkg::t_qent     i_q_ent,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fmti_pkg::t_out_word o_out_word
);

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_LERPA, B_LERPB, B_OUT} t_bstate;

    t_bstate                        r_state;
    fmti_pkg::t_qent                r_ent;
    logic [3:0]                     r_cnt;
    logic [fmti_pkg::ADDR_W-1:0]    r_clr;
    fmti_pkg::t_vec3                r_slot [8];
    logic [3:0]                     r_nval;
    logic [2:0]                     r_step;
    logic signed [49:0]             r_prod [3];
    logic signed [31:0]             r_a [3];
    fmti_pkg::t_out_word            r_res;
    logic                           r_out_valid;
    fmti_pkg::t_out_word            r_out_word;

    logic                           ram_we;
    logic [fmti_pkg::ADDR_W-1:0]    ram_waddr;
    logic [fmti_pkg::VEC_W-1:0]     ram_wdata;
    logic                           ram_re;
    logic [fmti_pkg::ADDR_W-1:0]    ram_raddr;
    logic [fmti_pkg::VEC_W-1:0]     ram_rdata;

    logic signed [31:0]             opa [3];
    logic signed [31:0]             opb [3];
    logic signed [32:0]             bd [3];
    logic signed [49:0]             prodc [3];
    logic signed [31:0]             res [3];
    logic [15:0]                    dsel;
    logic [fmti_pkg::IDX_W-1:0]     ci, cj, ck;

    fmti_ram #(
        .WIDTH(fmti_pkg::VEC_W),
        .DEPTH(fmti_pkg::CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_q_pop     = (r_state == B_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Corner number: bit 2 selects x, bit 1 y, bit 0 z.
    always_comb begin
        ci = r_cnt[2] ? r_ent.hi[0] : r_ent.lo[0];
        cj = r_cnt[1] ? r_ent.hi[1] : r_ent.lo[1];
        ck = r_cnt[0] ? r_ent.hi[2] : r_ent.lo[2];
        ram_raddr = fmti_pkg::cell_addr(32'(ci), 32'(cj), 32'(ck));
        ram_re    = (r_state == B_READ) && !r_cnt[3];
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (r_state == B_CLEAR) begin
            ram_we = 1'b1;
        end else if (o_q_pop && (i_q_ent.op == fmti_pkg::OP_LOAD) && i_q_ent.ldok) begin
            ram_we    = 1'b1;
            ram_waddr = i_q_ent.addr;
            ram_wdata = i_q_ent.data;
        end
    end

    // Shared lerp unit, z pairs first, then y, then x.
    always_comb begin
        if (r_step < 3'd4) begin
            dsel = r_ent.d[2];
        end else if (r_step < 3'd6) begin
            dsel = r_ent.d[1];
        end else begin
            dsel = r_ent.d[0];
        end
        opa[0] = r_slot[0].x;  opb[0] = r_slot[1].x;
        opa[1] = r_slot[0].y;  opb[1] = r_slot[1].y;
        opa[2] = r_slot[0].z;  opb[2] = r_slot[1].z;
        for (int c = 0; c < 3; c++) begin
            bd[c]    = {opb[c][31], opb[c]} - {opa[c][31], opa[c]};
            prodc[c] = bd[c] * $signed({1'b0, dsel});
            res[c]   = r_a[c] + 32'((r_prod[c] + 50'sd32768) >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != B_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == fmti_pkg::ADDR_W'(fmti_pkg::CELLS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_ent <= i_q_ent;
                        if (i_q_ent.op == fmti_pkg::OP_QUERY) begin
                            if (i_q_ent.outside) begin
                                r_res   <= '{field_x: '0, field_y: '0, field_z: '0,
                                             outside: 1'b1};
                                r_state <= B_OUT;
                            end else begin
                                r_cnt   <= '0;
                                r_state <= B_READ;
                            end
                        end
                    end
                end
                B_READ: begin
                    if (r_cnt != '0) begin
                        r_slot[r_cnt[2:0] - 3'd1] <= ram_rdata;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[3]) begin
                        r_nval  <= 4'd8;
                        r_step  <= '0;
                        r_state <= B_LERPA;
                    end
                end
                B_LERPA: begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[c] <= prodc[c];
                        r_a[c]    <= opa[c];
                    end
                    r_state <= B_LERPB;
                end
                B_LERPB: begin
                    if (r_step == 3'd6) begin
                        r_res   <= '{field_x: res[0], field_y: res[1], field_z: res[2],
                                     outside: 1'b0};
                        r_state <= B_OUT;
                    end else begin
                        // Drop the consumed pair and append the blended value.
                        for (int s = 0; s < 6; s++) begin
                            if (3'(s) != r_nval[2:0] - 3'd2) begin
                                r_slot[s] <= r_slot[s + 2];
                            end
                        end
                        r_slot[r_nval[2:0] - 3'd2] <= '{x: res[0], y: res[1], z: res[2]};
                        r_nval  <= r_nval - 1'b1;
                        r_step  <= r_step + 1'b1;
                        r_state <= B_LERPA;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_word  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_q_pop)
        else $error("queue popped during clearing pass");

    a_lerp_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LERPA) |-> (r_nval >= 4'd2))
        else $error("lerp issued with fewer than two operands");

    a_no_write_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_READ) |-> !ram_we)
        else $error("grid written while reading corners");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_word))
        else $error("result word changed while stalled");

endmodule

// ===== src/field_map_trilinear_interp.sv =====
// ----------------------------------------------------------------------------
// field_map_trilinear_interp
// Trilinear interpolation of a three-component field on a 3D grid.
// ----------------------------------------------------------------------------
// A query passes the front (a difference step, then a multiply and a locate
// step per axis, then the push) and then the back: the pop, the reads of the
// eight corners from the single read port of the grid memory, seven blends on
// one lerp unit, the output stage. A query off the grid skips the other steps.
// The back pops a new entry only once the last one has left it; a load goes straight to the push.
// After reset the grid is cleared one cell per cycle, all 32768 cells, first.
// ----------------------------------------------------------------------------
module field_map_trilinear_interp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fmti_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fmti_pkg::t_out_word o_out_word
);

    // The front turns each accepted word into a queue entry: loads carry
    // their address and data, queries carry the two neighbor indexes and the
    // blend fraction per axis, or the outside flag.
    logic            push;
    logic            full;
    logic            q_valid;
    logic            q_pop;
    logic            clearing;
    fmti_pkg::t_qent push_ent;
    fmti_pkg::t_qent q_ent;

    fmti_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_clearing (clearing),
        .o_push     (push),
        .o_ent      (push_ent),
        .i_full     (full)
    );

    // The queue lets the front locate the next query while the back is
    // still blending, or while a result waits at the output register.
    fmti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    // The back serializes all grid memory traffic in queue order, so a load
    // is always visible to every later query.
    fmti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_ent),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== tb/sv/fmti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmti_checker
// Watches the configuration port and both word channels of the trilinear
// field-map block, keeps its own copy of the grid and the registers, predicts
// every query result and compares each result word, field by field.
// ----------------------------------------------------------------------------
module fmti_checker
    import fmti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_outside
);

    int          grid_x_mem [CELLS];
    int          grid_y_mem [CELLS];
    int          grid_z_mem [CELLS];
    logic [31:0] origin_reg [3];
    logic [31:0] inv_reg    [3];
    t_out_word   field_q [$];

    assign o_pending = field_q.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic int cell_index(input int i, input int j, input int k);
        return (i * GRID_Y + j) * GRID_Z + k;
    endfunction

    // Finds the two neighbouring bin centres on one axis and the Q16 weight.
    // Returns 0 when the position falls off the grid.
    function automatic logic locate_axis(input logic signed [31:0] pos,
                                         input logic signed [31:0] org,
                                         input logic [31:0] inv, input int n,
                                         output int lo, output int hi,
                                         output longint d);
        longint      diff;
        logic [63:0] p;
        longint      lower;
        logic [15:0] f;
        diff = longint'(pos) - longint'(org);
        if (inv == 0) begin
            p = 64'd0;
        end else begin
            if (diff < 0) return 1'b0;
            if (diff > 64'sh0_FFFF_FFFF) return 1'b0;
            p = 64'(diff) * {32'd0, inv};
        end
        if (p[63:32] >= n) return 1'b0;
        f = p[31:16];
        if (f < 16'h8000) begin
            lower = longint'(p[63:32]) - 1;
            d = longint'(f) + 32768;
        end else begin
            lower = longint'(p[63:32]);
            d = longint'(f) - 32768;
        end
        if (lower < 0) begin
            lo = 0; hi = 0; d = 0;
        end else if (lower >= n - 1) begin
            lo = n - 1; hi = n - 1; d = 0;
        end else begin
            lo = int'(lower); hi = int'(lower) + 1;
        end
        return 1'b1;
    endfunction

    // Rounded linear step; the arithmetic shift gives the floor.
    function automatic longint lerp_q16(input longint a, input longint b, input longint d);
        return a + (((b - a) * d + 32768) >>> 16);
    endfunction

    function automatic longint blend_component(input int comp, input int lo[3],
                                               input int hi[3], input longint d[3]);
        longint v [8];
        longint a1, a2, b1, b2;
        for (int c = 0; c < 8; c++) begin
            int ci, cj, ck, idx;
            ci = c[2] ? hi[0] : lo[0];
            cj = c[1] ? hi[1] : lo[1];
            ck = c[0] ? hi[2] : lo[2];
            idx = cell_index(ci, cj, ck);
            v[c] = (comp == 0) ? grid_x_mem[idx] : (comp == 1) ? grid_y_mem[idx]
                                                               : grid_z_mem[idx];
        end
        a1 = lerp_q16(v[0], v[1], d[2]);
        a2 = lerp_q16(v[2], v[3], d[2]);
        b1 = lerp_q16(v[4], v[5], d[2]);
        b2 = lerp_q16(v[6], v[7], d[2]);
        return lerp_q16(lerp_q16(a1, a2, d[1]), lerp_q16(b1, b2, d[1]), d[0]);
    endfunction

    function automatic t_out_word predict_field(input t_in_word w);
        t_out_word r;
        int        lo [3];
        int        hi [3];
        longint    d  [3];
        logic      ok;
        ok = locate_axis(w.pos_x, origin_reg[0], inv_reg[0], GRID_X, lo[0], hi[0], d[0]);
        if (ok) ok = locate_axis(w.pos_y, origin_reg[1], inv_reg[1], GRID_Y,
                                 lo[1], hi[1], d[1]);
        if (ok) ok = locate_axis(w.pos_z, origin_reg[2], inv_reg[2], GRID_Z,
                                 lo[2], hi[2], d[2]);
        r = '0;
        if (!ok) begin
            r.outside = 1'b1;
        end else begin
            r.field_x = 32'(blend_component(0, lo, hi, d));
            r.field_y = 32'(blend_component(1, lo, hi, d));
            r.field_z = 32'(blend_component(2, lo, hi, d));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++) begin
                grid_x_mem[c] = 0; grid_y_mem[c] = 0; grid_z_mem[c] = 0;
            end
            for (int a = 0; a < 3; a++) begin
                origin_reg[a] = 32'd0; inv_reg[a] = 32'd65536;
            end
            field_q.delete();
            o_errors  = 0;
            o_results = 0;
            o_outside = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx <= CFG_ORIGIN_Z) origin_reg[i_cfg_idx] = i_cfg_data;
                else if (i_cfg_idx <= CFG_INV_Z) inv_reg[i_cfg_idx - CFG_INV_X] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                t_out_word want;
                o_results++;
                if (field_q.size() == 0) begin
                    $display("MISMATCH unexpected result word at %0t", $realtime);
                    o_errors++;
                end else begin
                    want = field_q.pop_front();
                    if (want.outside) o_outside++;
                    if (i_out_word.field_x !== want.field_x)
                        report_mismatch("field_x", i_out_word.field_x, want.field_x);
                    if (i_out_word.field_y !== want.field_y)
                        report_mismatch("field_y", i_out_word.field_y, want.field_y);
                    if (i_out_word.field_z !== want.field_z)
                        report_mismatch("field_z", i_out_word.field_z, want.field_z);
                    if (i_out_word.outside !== want.outside)
                        report_mismatch("outside", 32'(i_out_word.outside),
                                        32'(want.outside));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_word.opcode == OP_LOAD) begin
                    int idx;
                    idx = cell_index(i_in_word.cell_i, i_in_word.cell_j, i_in_word.cell_k);
                    grid_x_mem[idx] = i_in_word.load_bx;
                    grid_y_mem[idx] = i_in_word.load_by;
                    grid_z_mem[idx] = i_in_word.load_bz;
                end else begin
                    field_q.push_back(predict_field(i_in_word));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_field_map_trilinear_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_field_map_trilinear_interp
// Stimulus and verdict for the trilinear field-map block. A directed part
// loads extreme field values and queries the grid edges and half-bin limits;
// then several register settings each get random loads and queries, mostly
// aimed inside the grid. Checking is done by fmti_checker.
// ----------------------------------------------------------------------------
module tb_field_map_trilinear_interp;
    import fmti_pkg::*;

    // Register indexes past the last one; writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    // Cycles without any accepted word before the run is declared hung. The
    // grid clearing pass after reset moves no word, so this sits well above
    // its length.
    localparam int HANG_LIMIT = 120000;
    localparam int ONE = 65536;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_ready;
    t_out_word   out_word;

    int          errors, pending, results, outside_cnt;
    int          sent_items;
    bit          long_stall_req;
    bit          send_busy_mode;
    bit          recv_busy_mode;
    logic [31:0] cur_origin [3];
    logic [31:0] cur_inv    [3];

    field_map_trilinear_interp dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    fmti_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_word  (in_word),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_word (out_word),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_outside  (outside_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: any cycle in which no word moves on either channel counts
    // toward the hang limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= HANG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side. Before each result word the receiver idles a random number
    // of cycles, unless the current phase runs it flat out. On request it also
    // holds ready low for a long stretch so that the block backs up.
    initial begin : receiver
        int gap;
        out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_stall_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_stall_req = 1'b0;
            end
            gap = recv_busy_mode ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    // Offers one word and waits until it is accepted. The gap before it is
    // drawn per word; valid stays high between back-to-back words.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = send_busy_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    // Lets the block drain completely, then some extra cycles since a load
    // that gives no result may still be in flight.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // All six registers in one go, plus the two unused indexes now and then.
    task automatic set_registers(input logic [31:0] org [3], input logic [31:0] inv [3],
                                 input bit spare);
        for (int a = 0; a < 3; a++) begin
            cfg_we <= 1'b1; cfg_idx <= 3'(CFG_ORIGIN_X + a); cfg_data <= org[a];
            @(posedge i_clk);
            cfg_we <= 1'b1; cfg_idx <= 3'(CFG_INV_X + a); cfg_data <= inv[a];
            @(posedge i_clk);
            cur_origin[a] = org[a];
            cur_inv[a]    = inv[a];
        end
        if (spare) begin
            cfg_we <= 1'b1; cfg_idx <= CFG_SPARE_A; cfg_data <= $urandom();
            @(posedge i_clk);
            cfg_we <= 1'b1; cfg_idx <= CFG_SPARE_B; cfg_data <= $urandom();
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word load_word(input int i, input int j, input int k,
                                           input logic [31:0] bx, input logic [31:0] by,
                                           input logic [31:0] bz);
        t_in_word w;
        w = '0;
        w.opcode = OP_LOAD;
        w.cell_i = 5'(i); w.cell_j = 5'(j); w.cell_k = 5'(k);
        w.load_bx = bx; w.load_by = by; w.load_bz = bz;
        // Position bits are don't-care for a load; fill them anyway.
        w.pos_x = $urandom(); w.pos_y = $urandom(); w.pos_z = $urandom();
        return w;
    endfunction

    function automatic t_in_word query_word(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz);
        t_in_word w;
        w = '0;
        w.opcode = OP_QUERY;
        w.pos_x = px; w.pos_y = py; w.pos_z = pz;
        // Load fields are don't-care for a query.
        w.cell_i = 5'($urandom()); w.cell_j = 5'($urandom()); w.cell_k = 5'($urandom());
        w.load_bx = $urandom(); w.load_by = $urandom(); w.load_bz = $urandom();
        return w;
    endfunction

    // A position that usually lands on the grid (or just past its far edge)
    // under the current registers.
    function automatic logic [31:0] aimed_pos(input int a);
        longint span;
        if (cur_inv[a] == 0) return $urandom();
        span = (longint'(33) <<< 32) / longint'(cur_inv[a]);
        if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
        return cur_origin[a] + 32'($urandom_range(0, int'(span)));
    endfunction

    function automatic logic [31:0] field_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 2000) - 1000;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_word();
        logic [31:0] p [3];
        if ($urandom_range(0, 99) < 35) begin
            send_word(load_word($urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 31), field_value(), field_value(),
                                field_value()));
        end else begin
            for (int a = 0; a < 3; a++)
                p[a] = ($urandom_range(0, 99) < 12) ? $urandom() : aimed_pos(a);
            send_word(query_word(p[0], p[1], p[2]));
        end
    endtask

    initial begin : stimulus
        logic [31:0] org [3];
        logic [31:0] inv [3];
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_ORIGIN_X;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        in_word  = '0;
        sent_items     = 0;
        long_stall_req = 1'b0;
        send_busy_mode = 1'b0;
        recv_busy_mode = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with unit bin width and the origin at zero.
        org = '{32'd0, 32'd0, 32'd0};
        inv = '{ONE, ONE, ONE};
        set_registers(org, inv, 1'b1);
        send_word(load_word(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1));
        send_word(load_word(31, 31, 31, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_word(load_word(5, 5, 5, 32'h7FFF_FFFF, 32'd1000, 32'h8000_0000));
        send_word(load_word(6, 5, 5, 32'h8000_0000, 32'hFFFF_FC18, 32'h7FFF_FFFF));
        send_word(load_word(1, 0, 0, 32'd65536, 32'd3, 32'hFFFF_FFFD));
        // First half of the first bin, exact first centre, far half of the
        // last bin, just inside and just past the far edge, negative position.
        send_word(query_word(32'd0, 32'd0, 32'd0));
        send_word(query_word(32'h8000, 32'h8000, 32'h8000));
        send_word(query_word(32'h001F_C000, 32'h001F_C000, 32'h001F_C000));
        send_word(query_word(32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF));
        send_word(query_word(32'h0020_0000, 32'd0, 32'd0));
        send_word(query_word(32'd0, 32'hFFFF_FFFF, 32'd0));
        send_word(query_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
        // Blends between the two extreme cells at several weights.
        send_word(query_word(32'h0006_0000, 32'h0005_8000, 32'h0005_8000));
        send_word(query_word(32'h0005_C000, 32'h0005_8000, 32'h0005_8000));
        send_word(query_word(32'h0005_8001, 32'h0005_A000, 32'h0005_7FFF));
        send_word(query_word(32'h0001_0000, 32'h0000_4000, 32'h0000_C000));
        drain_block();

        // Zero inverse width: any position maps to cell zero.
        org = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
        inv = '{32'd0, 32'd0, 32'd0};
        set_registers(org, inv, 1'b0);
        send_word(query_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_word(query_word($urandom(), $urandom(), $urandom()));
        // Widest inverse width with the origin at the most negative value.
        drain_block();
        org = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        inv = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        set_registers(org, inv, 1'b0);
        send_word(query_word(32'h8000_0000, 32'h8000_0010, 32'h8000_001F));
        send_word(query_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));

        // Random phases, each under its own register setting and idling mix.
        for (int ph = 0; ph < 7; ph++) begin
            drain_block();
            for (int a = 0; a < 3; a++) begin
                case (ph)
                    0: begin org[a] = 32'd0; inv[a] = ONE; end
                    1: begin org[a] = 32'h7FFF_FFFF; inv[a] = 32'd0; end
                    2: begin org[a] = 32'h8000_0000; inv[a] = 32'hFFFF_FFFF; end
                    default: begin
                        org[a] = $urandom();
                        inv[a] = $urandom_range(32'h4000, 32'h40000);
                    end
                endcase
            end
            set_registers(org, inv, ph == 3);
            send_busy_mode = (ph % 3 == 1);
            recv_busy_mode = (ph % 3 == 2);
            for (int n = 0; n < 110; n++) begin
                // Partway through one phase, stall the result side for a long
                // stretch while words keep coming, so the block fills up.
                if (ph == 4 && n == 40) long_stall_req = 1'b1;
                random_word();
            end
        end

        // Wind down: wait for every expected result, then a margin for the
        // block's latency.
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d words; %0d results checked, %0d of them off the grid,",
                 sent_items, results, outside_cnt);
        $display("over ten register settings including zero and full-scale widths.");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/fmti_pkg.sv
src/fmti_ram.sv
src/fmti_queue.sv
src/fmti_front.sv
src/fmti_back.sv
src/field_map_trilinear_interp.sv
tb/sv/fmti_checker.sv
tb/sv/tb_field_map_trilinear_interp.sv
